>>> rtl/htfd_pkg.sv
// Package for the humidity/temperature frame decoder.
// Holds the byte positions, status codes, frame struct, CRC-8 step and the
// divide-by-full-scale helper. No dependencies.
package htfd_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    localparam int WORD_W = 16;
    localparam int PROD_W = 31;
    localparam int QUOT_W = 15;

    localparam logic [QUOT_W-1:0]       TEMP_SPAN   = 15'd17500;
    localparam logic [QUOT_W-1:0]       HUM_SPAN    = 15'd12500;
    localparam logic [PROD_W-1:0]       ROUND_HALF  = 31'd32767;
    localparam logic [WORD_W-1:0]       FULL_SCALE  = 16'hFFFF;
    localparam logic signed [15:0]      TEMP_OFFSET = 16'sd4500;
    localparam logic signed [15:0]      HUM_OFFSET  = 16'sd600;
    localparam logic signed [15:0]      HUM_MAX     = 16'sd10000;

    typedef logic [2:0] t_pos;
    localparam t_pos POS_T_MSB = 3'd0;
    localparam t_pos POS_T_LSB = 3'd1;
    localparam t_pos POS_T_CRC = 3'd2;
    localparam t_pos POS_H_MSB = 3'd3;
    localparam t_pos POS_H_LSB = 3'd4;
    localparam t_pos POS_H_CRC = 3'd5;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TEMP_CRC = 2'd1,
        STATUS_HUM_CRC  = 2'd2
    } t_status;

    typedef struct packed {
        logic [WORD_W-1:0] temp_word;
        logic [WORD_W-1:0] humid_word;
        t_status           status;
    } t_frame;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // floor(x / 65535): x = q0*65535 + (lo + q0), remainder stays below 2*65535
    function automatic logic [QUOT_W-1:0] div_full_scale(input logic [PROD_W-1:0] x);
        logic [QUOT_W-1:0] q0;
        logic [16:0]       r;
        q0 = x[PROD_W-1:16];
        r  = {1'b0, x[15:0]} + {2'b00, q0};
        return (r >= {1'b0, FULL_SCALE}) ? q0 + 15'd1 : q0;
    endfunction

endpackage

>>> rtl/humidity_temp_frame_decoder_core.sv
// The sixth byte loads r_v1; the result then moves via r_v2 and r_v3.
// Throughput: one byte per cycle; the frame register and two conversion
// stages each hold one request, so input stalls only when all are full.
// Byte position, CRC and word holds update as each byte is accepted.
// Reset (synchronous, active low) clears position, CRC to 0xFF, holds and
// all stage valid flags.
module humidity_temp_frame_decoder_core
    import htfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_frame_start,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [14:0]    o_temp_centi_c,
    output logic [13:0]           o_humidity_centi_pct,
    output logic [1:0]            o_status,
    output logic [15:0]           o_temp_word,
    output logic [15:0]           o_humid_word
);

    t_pos        r_pos;
    logic [7:0]  r_crc;
    logic [15:0] r_temp_hold;
    logic [15:0] r_humid_hold;
    logic        r_temp_bad;
    logic        r_v1;
    t_frame      r_frame;

    t_pos        n_pos;
    logic [7:0]  n_crc;
    logic [15:0] n_temp_hold;
    logic [15:0] n_humid_hold;
    logic        n_temp_bad;
    logic        n_last;
    t_status     n_status;

    t_pos        pos_eff;
    logic        conv_ready;
    logic        ready1;
    logic        accept;

    assign ready1  = !r_v1 || conv_ready;
    assign o_stall = !ready1;
    assign accept  = i_valid && ready1;

    always_comb begin
        pos_eff      = (i_frame_start || r_pos > POS_H_CRC) ? POS_T_MSB : r_pos;
        n_pos        = pos_eff + 3'd1;
        n_crc        = r_crc;
        n_temp_hold  = r_temp_hold;
        n_humid_hold = r_humid_hold;
        n_temp_bad   = r_temp_bad;
        n_last       = 1'b0;
        n_status     = STATUS_OK;
        case (pos_eff)
            POS_T_MSB: begin
                n_temp_hold[15:8] = i_rx_byte;
                n_crc = crc8_feed(CRC_INIT, i_rx_byte);
            end
            POS_T_LSB: begin
                n_temp_hold[7:0] = i_rx_byte;
                n_crc = crc8_feed(r_crc, i_rx_byte);
            end
            POS_T_CRC: begin
                n_temp_bad = (r_crc != i_rx_byte);
                n_crc      = CRC_INIT;
            end
            POS_H_MSB: begin
                n_humid_hold[15:8] = i_rx_byte;
                n_crc = crc8_feed(CRC_INIT, i_rx_byte);
            end
            POS_H_LSB: begin
                n_humid_hold[7:0] = i_rx_byte;
                n_crc = crc8_feed(r_crc, i_rx_byte);
            end
            POS_H_CRC: begin
                n_last = 1'b1;
                if (r_temp_bad) begin
                    n_status = STATUS_TEMP_CRC;
                end else if (r_crc != i_rx_byte) begin
                    n_status = STATUS_HUM_CRC;
                end
                n_pos      = POS_T_MSB;
                n_crc      = CRC_INIT;
                n_temp_bad = 1'b0;
            end
            default: begin
                n_pos = POS_T_MSB;
                n_crc = CRC_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= POS_T_MSB;
            r_crc        <= CRC_INIT;
            r_temp_hold  <= '0;
            r_humid_hold <= '0;
            r_temp_bad   <= 1'b0;
            r_v1         <= 1'b0;
        end else begin
            if (accept) begin
                r_pos        <= n_pos;
                r_crc        <= n_crc;
                r_temp_hold  <= n_temp_hold;
                r_humid_hold <= n_humid_hold;
                r_temp_bad   <= n_temp_bad;
            end
            if (ready1) begin
                r_v1 <= accept && n_last;
            end
        end
    end

    // both words are complete by the last byte, so the holds are taken as is
    always_ff @(posedge i_clk) begin
        if (accept && n_last) begin
            r_frame.temp_word  <= r_temp_hold;
            r_frame.humid_word <= r_humid_hold;
            r_frame.status     <= n_status;
        end
    end

    htfd_conv u_conv (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_frame_valid        (r_v1),
        .i_frame              (r_frame),
        .o_frame_ready        (conv_ready),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_temp_centi_c       (o_temp_centi_c),
        .o_humidity_centi_pct (o_humidity_centi_pct),
        .o_status             (o_status),
        .o_temp_word          (o_temp_word),
        .o_humid_word         (o_humid_word)
    );

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_H_CRC)
        else $error("byte position out of range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STATUS_OK |-> o_temp_centi_c == 15'sd0
            && o_humidity_centi_pct == 14'd0)
        else $error("error result carries nonzero values");

    a_hum_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_humidity_centi_pct <= 14'd10000)
        else $error("humidity above clamp");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v1 && o_valid && i_stall)
        else $error("input stalled with room in the pipeline");

endmodule

>>> rtl/htfd_conv.sv
// Conversion pipeline: scale multiply, divide by full scale with rounding,
// offset, clamp and output register. Depends on htfd_pkg.
module htfd_conv
    import htfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_frame_valid,
    input  t_frame                i_frame,
    output logic                  o_frame_ready,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [14:0]    o_temp_centi_c,
    output logic [13:0]           o_humidity_centi_pct,
    output logic [1:0]            o_status,
    output logic [15:0]           o_temp_word,
    output logic [15:0]           o_humid_word
);

    logic              r_v2;
    logic [PROD_W-1:0] r_p_temp;
    logic [PROD_W-1:0] r_p_hum;
    t_frame            r_f2;

    logic              r_v3;
    logic [14:0]       r_temp;
    logic [13:0]       r_hum;
    t_frame            r_f3;

    logic              ready2;
    logic              ready3;

    logic [QUOT_W-1:0] q_temp;
    logic [QUOT_W-1:0] q_hum;
    logic signed [15:0] t_val;
    logic signed [15:0] h_val;
    logic signed [15:0] h_clamp;
    logic [14:0]       n_temp;
    logic [13:0]       n_hum;

    assign ready3        = !r_v3 || !i_stall;
    assign ready2        = !r_v2 || ready3;
    assign o_frame_ready = ready2;

    always_comb begin
        q_temp = div_full_scale(r_p_temp);
        q_hum  = div_full_scale(r_p_hum);
        t_val  = $signed({1'b0, q_temp}) - TEMP_OFFSET;
        h_val  = $signed({1'b0, q_hum}) - HUM_OFFSET;
        if (h_val < 16'sd0) begin
            h_clamp = 16'sd0;
        end else if (h_val > HUM_MAX) begin
            h_clamp = HUM_MAX;
        end else begin
            h_clamp = h_val;
        end
        if (r_f2.status == STATUS_OK) begin
            n_temp = t_val[14:0];
            n_hum  = h_clamp[13:0];
        end else begin
            n_temp = '0;
            n_hum  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ready2) begin
                r_v2 <= i_frame_valid;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2 && i_frame_valid) begin
            r_p_temp <= {15'b0, i_frame.temp_word} * {16'b0, TEMP_SPAN} + ROUND_HALF;
            r_p_hum  <= {15'b0, i_frame.humid_word} * {16'b0, HUM_SPAN} + ROUND_HALF;
            r_f2     <= i_frame;
        end
        if (ready3 && r_v2) begin
            r_temp <= n_temp;
            r_hum  <= n_hum;
            r_f3   <= r_f2;
        end
    end

    assign o_valid              = r_v3;
    assign o_temp_centi_c       = $signed(r_temp);
    assign o_humidity_centi_pct = r_hum;
    assign o_status             = r_f3.status;
    assign o_temp_word          = r_f3.temp_word;
    assign o_humid_word         = r_f3.humid_word;

endmodule
